// ===== design/ies_pkg.sv =====
// ----------------------------------------------------------------------------
// ies_pkg
// Types and constants shared by the interrupt entry sequencer modules.
// ----------------------------------------------------------------------------
package ies_pkg;

    typedef enum logic [1:0] {
        MODE_RESET = 2'd0,
        MODE_NMI   = 2'd1,
        MODE_IRQ   = 2'd2,
        MODE_RUN   = 2'd3
    } t_mode;

    localparam logic [7:0]  FLAG_I     = 8'h04;
    localparam logic [7:0]  FLAG_B     = 8'h10;
    localparam logic [7:0]  FLAG_U     = 8'h20;
    localparam logic [7:0]  SP_INIT    = 8'hFD;
    localparam logic [7:0]  STACK_PAGE = 8'h01;
    localparam logic [7:0]  VEC_PAGE   = 8'hFF;
    localparam logic [7:0]  VEC_RST_LO = 8'hFC;
    localparam logic [7:0]  VEC_RST_HI = 8'hFD;
    localparam logic [7:0]  VEC_NMI_LO = 8'hFA;
    localparam logic [7:0]  VEC_NMI_HI = 8'hFB;
    localparam logic [7:0]  VEC_IRQ_LO = 8'hFE;
    localparam logic [7:0]  VEC_IRQ_HI = 8'hFF;

    typedef struct packed {
        t_mode       mode;
        logic [2:0]  step;
        logic        executing;
        logic [7:0]  instr;
        logic [15:0] pc;
        logic [7:0]  sp;
        logic [7:0]  flags;
        logic [7:0]  vector_low;
        logic        nmi_waiting;
        logic        irq_waiting;
    } t_state;

    typedef struct packed {
        logic        reset_req;
        logic        nmi_req;
        logic        irq_req;
        logic [7:0]  read_data;
        logic        exec_done;
    } t_item;

    typedef struct packed {
        logic        bus_active;
        logic        bus_write;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic        opcode_fetched;
        logic [7:0]  opcode_byte;
        t_mode       cpu_mode;
        logic [15:0] prog_counter;
        logic [7:0]  stack_pointer;
        logic [7:0]  status_flags;
    } t_result;

endpackage

// ===== design/cpu_interrupt_entry_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// cpu_interrupt_entry_sequencer_core
// Reset, NMI and IRQ entry sequencer of a 6502-style CPU. One item is one
// CPU cycle; one result item per input item.
//
//   channel  dir  handshake           payload
//   input    in   i_valid / o_ready   reset_req nmi_req irq_req read_data
//                                     exec_done
//   result   out  o_valid / i_ready   bus_*, write_data, opcode_*, cpu_mode,
//                                     prog_counter, stack_pointer, status_flags
//
// An item passes through the input register and then the result
// register; one item per cycle sustained while the result side does not stall.
// The state update is made as the item leaves the input register.
// Reset (i_rst_n low) clears the valid flags and the sequencer state; the sequencer starts in reset mode.
// A stall on the result side holds both registers; o_ready stays high while
// the input register is empty or moving.
// ----------------------------------------------------------------------------
module cpu_interrupt_entry_sequencer_core
    import ies_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_reset_req,
    input  logic        i_nmi_req,
    input  logic        i_irq_req,
    input  logic [7:0]  i_read_data,
    input  logic        i_exec_done,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_bus_active,
    output logic        o_bus_write,
    output logic [15:0] o_bus_address,
    output logic [7:0]  o_write_data,
    output logic        o_opcode_fetched,
    output logic [7:0]  o_opcode_byte,
    output logic [1:0]  o_cpu_mode,
    output logic [15:0] o_prog_counter,
    output logic [7:0]  o_stack_pointer,
    output logic [7:0]  o_status_flags
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    logic    advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    ies_step u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{mode: MODE_RESET, default: '0};
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= '{reset_req: i_reset_req, nmi_req: i_nmi_req, irq_req: i_irq_req,
                        read_data: i_read_data, exec_done: i_exec_done};
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_bus_active     = r_result.bus_active;
    assign o_bus_write      = r_result.bus_write;
    assign o_bus_address    = r_result.bus_address;
    assign o_write_data     = r_result.write_data;
    assign o_opcode_fetched = r_result.opcode_fetched;
    assign o_opcode_byte    = r_result.opcode_byte;
    assign o_cpu_mode       = r_result.cpu_mode;
    assign o_prog_counter   = r_result.prog_counter;
    assign o_stack_pointer  = r_result.stack_pointer;
    assign o_status_flags   = r_result.status_flags;

    a_write_on_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bus_write |-> o_bus_active && o_bus_address[15:8] == STACK_PAGE)
        else $error("write outside stack page");

    a_fetch_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_opcode_fetched |-> o_cpu_mode == MODE_RUN && o_bus_active)
        else $error("opcode fetch outside run mode");

    a_idle_bus_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bus_active |-> !o_bus_write && o_bus_address == 16'h0000)
        else $error("idle bus cycle drives address or write");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> $stable(r_state) && r_out_valid)
        else $error("state moved while result stalled");

endmodule

// ===== design/ies_step.sv =====
// ----------------------------------------------------------------------------
// ies_step
// One CPU cycle of the reset / NMI / IRQ entry sequencer: next state and
// bus access from the current state and one input item.
// ----------------------------------------------------------------------------
module ies_step
    import ies_pkg::*;
(
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    t_state      s;
    logic        act;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        fetched;
    logic        do_entry;
    logic [7:0]  vec_lo;
    logic [7:0]  vec_hi;

    always_comb begin
        s           = i_state;
        act         = 1'b0;
        wr          = 1'b0;
        addr        = '0;
        wdata       = '0;
        fetched     = 1'b0;
        do_entry    = 1'b0;
        s.nmi_waiting = i_state.nmi_waiting | i_item.nmi_req;
        s.irq_waiting = i_state.irq_waiting | i_item.irq_req;
        if (i_item.reset_req) begin
            s.mode = MODE_RESET;
            s.step = 3'd0;
        end

        unique case (s.mode)
            MODE_RESET: begin
                unique case (s.step)
                    3'd0: begin
                        s.flags       = '0;
                        s.pc          = '0;
                        s.executing   = 1'b0;
                        s.instr       = '0;
                        s.nmi_waiting = 1'b0;
                        s.irq_waiting = 1'b0;
                        s.step        = 3'd1;
                    end
                    3'd1: begin
                        s.sp    = SP_INIT;
                        s.flags = s.flags | FLAG_I | FLAG_U;
                        s.step  = 3'd2;
                    end
                    3'd2: begin
                        act          = 1'b1;
                        addr         = {VEC_PAGE, VEC_RST_LO};
                        s.vector_low = i_item.read_data;
                        s.step       = 3'd3;
                    end
                    3'd3: begin
                        act  = 1'b1;
                        addr = {VEC_PAGE, VEC_RST_HI};
                        s.pc = {i_item.read_data, s.vector_low};
                        s.step = 3'd4;
                    end
                    default: begin
                        s.mode = MODE_RUN;
                        s.step = 3'd0;
                    end
                endcase
            end
            MODE_NMI, MODE_IRQ: begin
                do_entry = 1'b1;
            end
            default: begin
                if (!s.executing) begin
                    if (s.nmi_waiting) begin
                        s.nmi_waiting = 1'b0;
                        s.mode        = MODE_NMI;
                        s.step        = 3'd0;
                        do_entry      = 1'b1;
                    end else if (s.irq_waiting && ((s.flags & FLAG_I) == 8'h00)) begin
                        s.irq_waiting = 1'b0;
                        s.mode        = MODE_IRQ;
                        s.step        = 3'd0;
                        do_entry      = 1'b1;
                    end else begin
                        act         = 1'b1;
                        addr        = s.pc;
                        s.instr     = i_item.read_data;
                        s.pc        = s.pc + 16'd1;
                        s.executing = 1'b1;
                        fetched     = 1'b1;
                    end
                end else if (i_item.exec_done) begin
                    s.executing = 1'b0;
                end
            end
        endcase

        vec_lo = (s.mode == MODE_NMI) ? VEC_NMI_LO : VEC_IRQ_LO;
        vec_hi = (s.mode == MODE_NMI) ? VEC_NMI_HI : VEC_IRQ_HI;

        if (do_entry) begin
            unique case (s.step)
                3'd0: begin
                    act    = 1'b1;
                    addr   = s.pc;
                    s.step = 3'd1;
                end
                3'd1: begin
                    act    = 1'b1;
                    wr     = 1'b1;
                    addr   = {STACK_PAGE, s.sp};
                    wdata  = s.pc[15:8];
                    s.sp   = s.sp - 8'd1;
                    s.step = 3'd2;
                end
                3'd2: begin
                    act    = 1'b1;
                    wr     = 1'b1;
                    addr   = {STACK_PAGE, s.sp};
                    wdata  = s.pc[7:0];
                    s.sp   = s.sp - 8'd1;
                    s.step = 3'd3;
                end
                3'd3: begin
                    s.flags = (s.flags & ~FLAG_B) | FLAG_U;
                    act     = 1'b1;
                    wr      = 1'b1;
                    addr    = {STACK_PAGE, s.sp};
                    wdata   = s.flags;
                    s.sp    = s.sp - 8'd1;
                    s.step  = 3'd4;
                end
                3'd4: begin
                    s.flags = s.flags | FLAG_I;
                    s.step  = 3'd5;
                end
                3'd5: begin
                    act     = 1'b1;
                    addr    = {VEC_PAGE, vec_lo};
                    s.pc    = {s.pc[15:8], i_item.read_data};
                    s.step  = 3'd6;
                end
                default: begin
                    act    = 1'b1;
                    addr   = {VEC_PAGE, vec_hi};
                    s.pc   = {i_item.read_data, s.pc[7:0]};
                    s.mode = MODE_RUN;
                    s.step = 3'd0;
                end
            endcase
        end

        o_state                  = s;
        o_result.bus_active      = act;
        o_result.bus_write       = wr;
        o_result.bus_address     = addr;
        o_result.write_data      = wdata;
        o_result.opcode_fetched  = fetched;
        o_result.opcode_byte     = s.instr;
        o_result.cpu_mode        = s.mode;
        o_result.prog_counter    = s.pc;
        o_result.stack_pointer   = s.sp;
        o_result.status_flags    = s.flags;
    end

endmodule
